@@ sv/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants shared by the fixed-point ALU modules.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // command codes
    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_GT  = 4'd4,
        CMD_LT  = 4'd5,
        CMD_GE  = 4'd6,
        CMD_LE  = 4'd7,
        CMD_EQ  = 4'd8,
        CMD_NE  = 4'd9,
        CMD_MIN = 4'd10,
        CMD_MAX = 4'd11
    } t_cmd;

    // status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    // how the back end treats a queued item
    typedef enum logic [1:0] {
        KIND_DONE = 2'd0,
        KIND_MUL  = 2'd1,
        KIND_DIV  = 2'd2
    } t_kind;

    localparam int unsigned DIV_STEPS = 33;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic [1:0]         status;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] res;
        logic        cmp;
        t_status     st;
        logic        neg;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
    } t_job;

endpackage

@@ sv/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// Classifies an item and finishes the operations that need no multiply or divide.
// ----------------------------------------------------------------------------
module fpa_front (
    input  fpa_pkg::t_in_item i_item,
    output fpa_pkg::t_job     o_job
);
    import fpa_pkg::*;

    logic signed [32:0] w_sum;
    logic signed [32:0] w_diff;
    logic               w_gt;
    logic               w_eq;

    // wide sum and difference with one guard bit
    assign w_sum  = {i_item.operand_a[31], i_item.operand_a}
                  + {i_item.operand_b[31], i_item.operand_b};
    assign w_diff = {i_item.operand_a[31], i_item.operand_a}
                  - {i_item.operand_b[31], i_item.operand_b};
    assign w_gt   = i_item.operand_a > i_item.operand_b;
    assign w_eq   = i_item.operand_a == i_item.operand_b;

    always_comb begin
        o_job       = '0;
        o_job.kind  = KIND_DONE;
        o_job.st    = ST_OK;
        o_job.neg   = i_item.operand_a[31] ^ i_item.operand_b[31];
        // magnitudes, the most negative value maps to 2^31
        o_job.mag_a = i_item.operand_a[31] ? 32'(-i_item.operand_a) : i_item.operand_a;
        o_job.mag_b = i_item.operand_b[31] ? 32'(-i_item.operand_b) : i_item.operand_b;

        unique case (i_item.cmd)
            CMD_ADD: begin
                o_job.res = w_sum[31:0];
                if (w_sum[32] != w_sum[31]) begin
                    o_job.st  = ST_OVF;
                    o_job.res = w_sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                end
            end
            CMD_SUB: begin
                o_job.res = w_diff[31:0];
                if (w_diff[32] != w_diff[31]) begin
                    o_job.st  = ST_OVF;
                    o_job.res = w_diff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                end
            end
            CMD_MUL: o_job.kind = KIND_MUL;
            CMD_DIV: begin
                if (i_item.operand_b == '0) begin
                    o_job.st = ST_DIVZ;
                    if (i_item.operand_a[31]) begin
                        o_job.res = 32'h8000_0000;
                    end else if (i_item.operand_a != '0) begin
                        o_job.res = 32'h7fff_ffff;
                    end
                end else begin
                    o_job.kind = KIND_DIV;
                end
            end
            CMD_GT:  o_job.cmp = w_gt;
            CMD_LT:  o_job.cmp = !w_gt && !w_eq;
            CMD_GE:  o_job.cmp = w_gt || w_eq;
            CMD_LE:  o_job.cmp = !w_gt;
            CMD_EQ:  o_job.cmp = w_eq;
            CMD_NE:  o_job.cmp = !w_eq;
            CMD_MIN: o_job.res = (w_gt || w_eq) ? i_item.operand_b : i_item.operand_a;
            CMD_MAX: o_job.res = (w_gt || w_eq) ? i_item.operand_a : i_item.operand_b;
            default: o_job.res = '0;
        endcase
    end

endmodule

@@ sv/fpa_queue.sv @@
// ----------------------------------------------------------------------------
// fpa_queue
// Short queue between the front and the back end.
// ----------------------------------------------------------------------------
module fpa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fpa_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output fpa_pkg::t_job o_job
);
    import fpa_pkg::*;

    t_job       r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_count;
    logic [2:0] n_count;

    assign o_full  = r_count == 3'd4;
    assign o_empty = r_count == 3'd0;
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 3'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 3'd1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= n_count;
        end
    end

endmodule

@@ sv/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// Multiply and restoring-divide pipeline with rounding and saturation.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  fpa_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fpa_pkg::t_out_item o_out
);
    import fpa_pkg::*;

    localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] res;
        logic        cmp;
        t_status     st;
        logic        neg;
        logic [31:0] den;
        logic [63:0] rem;
        logic [32:0] quo;
        logic        big;
    } t_stage;

    t_stage      r_stage [DIV_STEPS + 1];
    t_stage      n_stage [DIV_STEPS + 1];
    t_out_item   r_out;
    logic        r_out_valid;
    logic        w_en;
    logic [63:0] w_num;
    logic [63:0] w_mag;
    logic [31:0] w_res;
    logic        w_ovf;
    t_out_item   w_final;

    // the whole pipe moves unless a result is held at the output
    assign w_en  = !r_out_valid || i_out_ready;
    assign o_pop = w_en && i_job_valid;
    assign w_num = {32'd0, i_job.mag_a} << FRAC_BITS;

    // entry stage and one quotient bit per later stage
    always_comb begin
        n_stage[0]       = '0;
        n_stage[0].valid = i_job_valid;
        n_stage[0].kind  = i_job.kind;
        n_stage[0].res   = i_job.res;
        n_stage[0].cmp   = i_job.cmp;
        n_stage[0].st    = i_job.st;
        n_stage[0].neg   = i_job.neg;
        n_stage[0].den   = i_job.mag_b;
        n_stage[0].rem   = (i_job.kind == KIND_MUL) ? i_job.mag_a * i_job.mag_b : w_num;
        // quotient too wide for the pipeline, only meaningful for a divide
        n_stage[0].big   = (i_job.kind == KIND_DIV)
                        && ({1'b0, w_num[63:33]} >= i_job.mag_b);
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_stage[k] = r_stage[k-1];
            if (r_stage[k-1].kind == KIND_DIV
                    && r_stage[k-1].rem >= ({32'd0, r_stage[k-1].den} << (DIV_STEPS - k))) begin
                n_stage[k].rem = r_stage[k-1].rem
                               - ({32'd0, r_stage[k-1].den} << (DIV_STEPS - k));
                n_stage[k].quo[DIV_STEPS - k] = 1'b1;
            end
        end
    end

    // rounded magnitude of the last stage
    always_comb begin
        if (r_stage[DIV_STEPS].kind == KIND_MUL) begin
            w_mag = (r_stage[DIV_STEPS].rem + HALF) >> FRAC_BITS;
        end else begin
            w_mag = {31'd0, r_stage[DIV_STEPS].quo}
                  + 64'({r_stage[DIV_STEPS].rem[31:0], 1'b0} >= {1'b0, r_stage[DIV_STEPS].den});
        end
    end

    // sign and saturation
    always_comb begin
        w_ovf = 1'b0;
        w_res = '0;
        if (r_stage[DIV_STEPS].neg) begin
            if (w_mag > 64'h8000_0000 || r_stage[DIV_STEPS].big) begin
                w_ovf = 1'b1;
                w_res = 32'h8000_0000;
            end else begin
                w_res = 32'(-w_mag[31:0]);
            end
        end else begin
            if (w_mag > 64'h7fff_ffff || r_stage[DIV_STEPS].big) begin
                w_ovf = 1'b1;
                w_res = 32'h7fff_ffff;
            end else begin
                w_res = w_mag[31:0];
            end
        end
        w_final.compare_true = r_stage[DIV_STEPS].cmp;
        if (r_stage[DIV_STEPS].kind == KIND_DONE) begin
            w_final.result_value = r_stage[DIV_STEPS].res;
            w_final.status       = r_stage[DIV_STEPS].st;
        end else begin
            w_final.result_value = w_res;
            w_final.status       = w_ovf ? ST_OVF : ST_OK;
        end
    end

    // pipeline payload and valid bits, only the valid bits are reset
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_stage[k].kind <= n_stage[k].kind;
                r_stage[k].res  <= n_stage[k].res;
                r_stage[k].cmp  <= n_stage[k].cmp;
                r_stage[k].st   <= n_stage[k].st;
                r_stage[k].neg  <= n_stage[k].neg;
                r_stage[k].den  <= n_stage[k].den;
                r_stage[k].rem  <= n_stage[k].rem;
                r_stage[k].quo  <= n_stage[k].quo;
                r_stage[k].big  <= n_stage[k].big;
            end
            r_out <= w_final;
        end
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_stage[k].valid <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_stage[k].valid <= n_stage[k].valid;
            end
            r_out_valid <= r_stage[DIV_STEPS].valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ sv/fixed_point_alu_unit.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed 32-bit fixed-point ALU: add, sub, mul, div, compares, min and max.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the queue is full or the output is held,
// and returns results in order. Every item passes through the same
// 33-step restoring divider pipeline; a four-entry queue sits between the
// input and that pipeline. Multiply and divide round half away from zero,
// and all arithmetic saturates with an overflow status.
module fixed_point_alu_unit #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fpa_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fpa_pkg::t_out_item o_out
);
    import fpa_pkg::*;

    t_job w_front_job;
    t_job w_head_job;
    logic w_full;
    logic w_empty;
    logic w_pop;

    assign o_in_ready = !w_full;

    fpa_front u_front (
        .i_item (i_in),
        .o_job  (w_front_job)
    );

    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !w_full),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_empty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

@@ sv/fpa_checker.sv @@
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU results.
// ----------------------------------------------------------------------------
module fpa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_ready,
    input logic               o_out_valid,
    input fpa_pkg::t_out_item o_out
);
    import fpa_pkg::*;

    // a comparison never carries a value
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.compare_true |-> o_out.result_value == '0)
        else $error("comparison item with non-zero value");

    // divide by zero never reports a comparison
    a_divz_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_DIVZ |-> !o_out.compare_true)
        else $error("divide-by-zero item with compare flag");

    // status stays within its codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status != 2'd3)
        else $error("undefined status code");

    // nothing leaves straight after reset
    a_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("held result changed");

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_ready (i_out_ready),
    .o_out_valid (o_out_valid),
    .o_out       (o_out)
);

@@ tb/fixed_point_alu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_checker
// Watches both channels of the fixed-point ALU, predicts each result from
// the accepted item and compares it field by field, oldest first.
// ----------------------------------------------------------------------------
module fixed_point_alu_checker #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  fpa_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  fpa_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_pending
);
    import fpa_pkg::*;

    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    t_out_item expected_q[$];

    // clamp a signed magnitude to 32 bits
    function automatic longint sat_mag(longint unsigned m, bit neg, ref t_status st);
        if (neg) begin
            if (m > 64'd2147483648) begin
                st = ST_OVF;
                return MIN32;
            end
            return -longint'(m);
        end
        if (m > 64'd2147483647) begin
            st = ST_OVF;
            return MAX32;
        end
        return longint'(m);
    endfunction

    // exact result of one alu item
    function automatic t_out_item alu_result(t_in_item it);
        longint a, b, r, s;
        longint unsigned ma, mb, p, num, q;
        bit neg, cmp;
        t_status st;
        t_out_item res;
        a = longint'(it.operand_a);
        b = longint'(it.operand_b);
        ma = a < 0 ? longint'(-a) : a;
        mb = b < 0 ? longint'(-b) : b;
        neg = (a < 0) != (b < 0);
        r = 0;
        cmp = 1'b0;
        st = ST_OK;
        case (it.cmd)
            CMD_ADD, CMD_SUB: begin
                s = (it.cmd == CMD_ADD) ? a + b : a - b;
                if (s > MAX32) begin
                    r = MAX32;
                    st = ST_OVF;
                end else if (s < MIN32) begin
                    r = MIN32;
                    st = ST_OVF;
                end else begin
                    r = s;
                end
            end
            CMD_MUL: begin
                p = ma * mb;
                q = (p + ((64'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
                r = sat_mag(q, neg, st);
            end
            CMD_DIV: begin
                if (b == 0) begin
                    st = ST_DIVZ;
                    r = a > 0 ? MAX32 : (a < 0 ? MIN32 : 0);
                end else begin
                    num = ma << FRAC_BITS;
                    q = (2 * num + mb) / (2 * mb);
                    r = sat_mag(q, neg, st);
                end
            end
            CMD_GT:  cmp = a > b;
            CMD_LT:  cmp = a < b;
            CMD_GE:  cmp = a >= b;
            CMD_LE:  cmp = a <= b;
            CMD_EQ:  cmp = a == b;
            CMD_NE:  cmp = a != b;
            CMD_MIN: r = (a >= b) ? b : a;
            CMD_MAX: r = (a >= b) ? a : b;
            default: ;
        endcase
        res.result_value = r[31:0];
        res.compare_true = cmp;
        res.status = st;
        return res;
    endfunction

    // predict on input, compare on output
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_q.push_back(alu_result(i_in));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected item: result_value %0d", i_out.result_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (exp_item !== i_out) begin
                        if (exp_item.result_value !== i_out.result_value)
                            $error("result_value expected %0d got %0d",
                                   exp_item.result_value, i_out.result_value);
                        if (exp_item.compare_true !== i_out.compare_true)
                            $error("compare_true expected %0d got %0d",
                                   exp_item.compare_true, i_out.compare_true);
                        if (exp_item.status !== i_out.status)
                            $error("status expected %0d got %0d",
                                   exp_item.status, i_out.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end
endmodule

@@ tb/fixed_point_alu_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_unit_test
// Drives directed and random items through the fixed-point ALU under varied
// idling on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit_test;
    import fpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;
    int        fail_count;
    int        pending;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        hold_reqs = 0;
    int        holds_done = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    fixed_point_alu_unit #(.FRAC_BITS(8)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    fixed_point_alu_checker #(.FRAC_BITS(8)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_reqs != holds_done) begin
            holds_done <= hold_reqs;
            hold_left <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offer one item, idling first at the current rate; valid stays high
    // after acceptance until the next falling edge
    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_op(t_cmd c, logic [31:0] a, logic [31:0] b);
        t_in_item it;
        it.cmd = c;
        it.operand_a = a;
        it.operand_b = b;
        send_item(it);
    endtask

    // operand mix: extremes, small values, rounding edges, full range
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: case ($urandom_range(0, 4))
                0: return 32'h7fffffff;
                1: return 32'h80000000;
                2: return 32'h0;
                3: return 32'hffffffff;
                default: return 32'h00000100;
            endcase
            1: return $urandom_range(0, 4096) - 2048;
            2: return ($urandom_range(0, 1) ? 32'h80 : 32'hffffff80) + $urandom_range(0, 2) - 1;
            3: return 32'($urandom) >>> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
        it.operand_a = pick_operand();
        it.operand_b = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand();
        if ($urandom_range(0, 9) == 0)
            it.operand_b = it.operand_a;
        return it;
    endfunction

    // stop offering and wait for every expected result
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: saturation, rounding, division by zero, compares, min and max, unused codes
        send_op(CMD_ADD, 32'h7fffffff, 32'h1);
        send_op(CMD_ADD, 32'h80000000, 32'hffffffff);
        send_op(CMD_SUB, 32'h80000000, 32'h1);
        send_op(CMD_SUB, 32'h7fffffff, 32'h80000000);
        send_op(CMD_MUL, 32'h80000000, 32'h80000000);
        send_op(CMD_MUL, 32'h80000000, 32'h100);
        send_op(CMD_MUL, 32'h80, 32'h1);
        send_op(CMD_MUL, 32'hffffff80, 32'h1);
        send_op(CMD_MUL, 32'h7fffffff, 32'hffffffff);
        send_op(CMD_DIV, 32'h0, 32'h0);
        send_op(CMD_DIV, 32'h500, 32'h0);
        send_op(CMD_DIV, 32'hfffffb00, 32'h0);
        send_op(CMD_DIV, 32'h100, 32'h300);
        send_op(CMD_DIV, 32'h80000000, 32'h1);
        send_op(CMD_DIV, 32'h80000000, 32'hffffff00);
        send_op(CMD_GT, 32'h5, 32'hfffffffb);
        send_op(CMD_LT, 32'h80000000, 32'h7fffffff);
        send_op(CMD_GE, 32'h7, 32'h7);
        send_op(CMD_LE, 32'h8, 32'h7);
        send_op(CMD_EQ, 32'h80000000, 32'h80000000);
        send_op(CMD_NE, 32'h1, 32'h1);
        send_op(CMD_MIN, 32'h3, 32'h3);
        send_op(CMD_MAX, 32'hffffffff, 32'h1);
        send_item('{cmd: 4'd12, operand_a: 32'h1, operand_b: 32'h2});
        send_item('{cmd: 4'd15, operand_a: 32'hffffffff, operand_b: 32'hffffffff});
        wait_drained();

        // random phases with differing idle rates
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
                3: begin tx_idle_pct = 33; rx_stall_pct = 33; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            // long receiver hold-off while items keep coming
            if (ph == 4)
                hold_reqs = hold_reqs + 1;
            for (int n = 0; n < 305; n++)
                send_item(random_item());
            // pause until everything has come back
            if (ph == 1 || ph == 4)
                wait_drained();
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
